// ===== rtl/spq_pkg.sv =====
// Shared types and constants for the sorted priority queue.
// Used by spq_cell and sorted_priority_queue_top; no dependencies.
package spq_pkg;

    // Queue geometry
    localparam int DEPTH  = 64;
    localparam int PRIO_W = 16;
    localparam int DATA_W = 32;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int OCC_W  = 7;

    // Opcodes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    // Result status codes
    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // One stored entry
    typedef struct packed {
        logic [PRIO_W-1:0] prio;
        logic [DATA_W-1:0] data;
    } entry_t;

    // Command broadcast to every cell of the chain
    typedef struct packed {
        logic   ins;
        logic   rem;
        entry_t entry;
    } cell_cmd_t;

endpackage

// ===== rtl/spq_cell.sv =====
// One cell of the shift-register priority queue chain.
// Depends on spq_pkg (entry_t, cell_cmd_t).
module spq_cell (
    input  logic               clk,
    input  spq_pkg::cell_cmd_t cmd,
    input  logic               occupied,
    input  logic               left_gt,
    input  spq_pkg::entry_t    left_entry,
    input  spq_pkg::entry_t    right_entry,
    output logic               gt,
    output spq_pkg::entry_t    entry
);

    spq_pkg::entry_t entry_reg;
    spq_pkg::entry_t entry_next;

    // An empty cell counts as larger than any priority
    assign gt = !occupied || (entry_reg.prio > cmd.entry.prio);

    // Insert: larger entries move right, the first larger slot takes the new one.
    // Remove: everything moves left.
    always_comb
    begin
        entry_next = entry_reg;
        if (cmd.ins && gt)
        begin
            entry_next = left_gt ? left_entry : cmd.entry;
        end
        else if (cmd.rem)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

// ===== rtl/sorted_priority_queue_top.sv =====
// Top level of the sorted priority queue: cell chain, fill count, result register.
// Depends on spq_pkg and spq_cell.

// Sorted priority queue holding up to 64 (priority, payload) entries in a chain
// of cells, smallest priority at the head, equal priorities in arrival order.
// Every cell compares its entry against the incoming priority in the same cycle,
// so an insert or a remove completes at the next edge and a new beat can be taken
// every cycle; the only stall comes from the result register, which accepts a
// new beat whenever it is empty or its result is taken in the same cycle. Each
// input beat yields exactly one result beat in the next cycle. Entries are not
// cleared at reset; the fill count alone marks which cells hold data, so the
// block is ready right after reset.
module sorted_priority_queue_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        opcode,
    input  logic [15:0]                 priority_req,
    input  logic signed [31:0]          payload,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [1:0]                  status,
    output logic [15:0]                 out_priority,
    output logic signed [31:0]          out_payload,
    output logic [spq_pkg::OCC_W-1:0]   occupancy
);

    logic [spq_pkg::CNT_W-1:0] count_reg;
    logic [spq_pkg::CNT_W-1:0] count_next;
    logic                      out_valid_reg;
    spq_pkg::status_t          status_reg;
    spq_pkg::status_t          status_next;
    spq_pkg::entry_t           result_reg;
    spq_pkg::entry_t           result_next;

    logic                      accept;
    logic                      is_full;
    logic                      is_empty;
    spq_pkg::cell_cmd_t        cmd;

    logic            gt_w    [spq_pkg::DEPTH];
    spq_pkg::entry_t entry_w [spq_pkg::DEPTH];

    // Handshake
    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign is_full  = (count_reg == spq_pkg::CNT_W'(spq_pkg::DEPTH));
    assign is_empty = (count_reg == '0);

    // Command broadcast to the chain
    always_comb
    begin
        cmd.ins        = accept && (opcode == spq_pkg::OP_INSERT) && !is_full;
        cmd.rem        = accept && (opcode == spq_pkg::OP_REMOVE) && !is_empty;
        cmd.entry.prio = priority_req[spq_pkg::PRIO_W-1:0];
        cmd.entry.data = payload;
    end

    // Cell chain
    for (genvar i = 0; i < spq_pkg::DEPTH; i++)
    begin : g_cell
        logic            occ;
        logic            lgt;
        spq_pkg::entry_t lent;
        spq_pkg::entry_t rent;

        assign occ = (spq_pkg::CNT_W'(i) < count_reg);

        if (i == 0)
        begin : g_head
            assign lgt  = 1'b0;
            assign lent = cmd.entry;
        end
        else
        begin : g_mid
            assign lgt  = gt_w[i-1];
            assign lent = entry_w[i-1];
        end

        if (i == spq_pkg::DEPTH - 1)
        begin : g_tail
            assign rent = entry_w[i];
        end
        else
        begin : g_body
            assign rent = entry_w[i+1];
        end

        spq_cell u_cell (
            .clk         (clk),
            .cmd         (cmd),
            .occupied    (occ),
            .left_gt     (lgt),
            .left_entry  (lent),
            .right_entry (rent),
            .gt          (gt_w[i]),
            .entry       (entry_w[i])
        );
    end

    // Result and fill count
    always_comb
    begin
        count_next  = count_reg;
        status_next = spq_pkg::ST_DONE;
        result_next = '0;
        if (opcode == spq_pkg::OP_INSERT)
        begin
            if (is_full)
            begin
                status_next = spq_pkg::ST_FULL;
            end
            else
            begin
                count_next = count_reg + 1'b1;
            end
        end
        else
        begin
            if (is_empty)
            begin
                status_next = spq_pkg::ST_EMPTY;
            end
            else
            begin
                result_next = entry_w[0];
                count_next  = count_reg - 1'b1;
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload register
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status_next;
            result_reg <= result_next;
        end
    end

    logic [spq_pkg::CNT_W-1:0] occ_q_reg;
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            occ_q_reg <= count_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign out_priority = 16'(result_reg.prio);
    assign out_payload  = result_reg.data;
    assign occupancy    = spq_pkg::OCC_W'(occ_q_reg);

    // Assertions
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= spq_pkg::CNT_W'(spq_pkg::DEPTH))
        else $error("fill count above depth");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> in_ready)
        else $error("input stalled with empty result register");

    a_remove_count: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && opcode == spq_pkg::OP_REMOVE && !is_empty)
        |=> count_reg == $past(count_reg) - 1'b1)
        else $error("remove did not shrink the queue");

    a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && opcode == spq_pkg::OP_INSERT && !is_full)
        |=> count_reg == $past(count_reg) + 1'b1)
        else $error("insert did not grow the queue");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg == spq_pkg::ST_FULL)
        |-> occ_q_reg == spq_pkg::CNT_W'(spq_pkg::DEPTH))
        else $error("full status with room left");

endmodule

// ===== verif/spq_check_pkg.sv =====
// Scoreboard for the sorted priority queue testbench: a software copy of the
// queue that predicts each result beat, and the checker for the result port.
// Depends on spq_pkg for geometry, opcodes and status codes.
package spq_check_pkg;

    // One predicted result beat
    typedef struct {
        spq_pkg::status_t                status;
        logic [spq_pkg::PRIO_W-1:0]      prio;
        logic [spq_pkg::DATA_W-1:0]      data;
        logic [spq_pkg::OCC_W-1:0]       occ;
    } queue_result_t;

    class queue_scoreboard;

        spq_pkg::entry_t held_entries[$];      // model queue, head at index 0
        queue_result_t   expected_results[$];  // oldest first
        int              errors;

        function new();
            errors = 0;
        endfunction

        function int outstanding();
            return expected_results.size();
        endfunction

        // Count a failure and report it
        function void flag(string what, logic [31:0] exp_val, logic [31:0] act_val);
            errors++;
            $display("%0t: %s mismatch, expected %h, actual %h",
                     $time, what, exp_val, act_val);
        endfunction

        // Apply one accepted request beat to the model and queue its result
        function void note_request(logic op, logic [spq_pkg::PRIO_W-1:0] pr,
                                   logic [spq_pkg::DATA_W-1:0] pl);
            queue_result_t   r;
            spq_pkg::entry_t e;
            int              pos;
            r.status = spq_pkg::ST_DONE;
            r.prio   = '0;
            r.data   = '0;
            if (op == spq_pkg::OP_INSERT)
            begin
                if (held_entries.size() >= spq_pkg::DEPTH)
                begin
                    r.status = spq_pkg::ST_FULL;
                end
                else
                begin
                    // new entry goes behind every entry of equal or smaller priority
                    pos = held_entries.size();
                    while (pos > 0 && held_entries[pos-1].prio > pr)
                        pos--;
                    e.prio = pr;
                    e.data = pl;
                    held_entries.insert(pos, e);
                end
            end
            else
            begin
                if (held_entries.size() == 0)
                begin
                    r.status = spq_pkg::ST_EMPTY;
                end
                else
                begin
                    e      = held_entries.pop_front();
                    r.prio = e.prio;
                    r.data = e.data;
                end
            end
            r.occ = spq_pkg::OCC_W'(held_entries.size());
            expected_results.push_back(r);
        endfunction

        // Compare one accepted result beat with the oldest prediction
        function void check_response(logic [1:0] st, logic [spq_pkg::PRIO_W-1:0] pr,
                                     logic [spq_pkg::DATA_W-1:0] pl,
                                     logic [spq_pkg::OCC_W-1:0] occ);
            queue_result_t r;
            if (expected_results.size() == 0)
            begin
                errors++;
                $display("%0t: result beat with nothing expected, status %h", $time, st);
                return;
            end
            r = expected_results.pop_front();
            if (st !== r.status)  flag("status", 32'(r.status), 32'(st));
            if (pr !== r.prio)    flag("out_priority", 32'(r.prio), 32'(pr));
            if (pl !== r.data)    flag("out_payload", 32'(r.data), 32'(pl));
            if (occ !== r.occ)    flag("occupancy", 32'(r.occ), 32'(occ));
        endfunction

    endclass

endpackage

// ===== verif/tb.sv =====
// Testbench for sorted_priority_queue_top: directed corner cases, then random
// fill/drain traffic under three sender/receiver stall mixes, checked beat by beat.
// Depends on spq_pkg and spq_check_pkg.
module tb;

    logic                          clk          = 1'b0;
    logic                          rst_n        = 1'b0;
    logic                          in_valid     = 1'b0;
    logic                          opcode       = spq_pkg::OP_INSERT;
    logic [15:0]                   priority_req = '0;
    logic signed [31:0]            payload      = '0;
    logic                          out_ready    = 1'b0;
    logic                          in_ready;
    logic                          out_valid;
    logic [1:0]                    status;
    logic [15:0]                   out_priority;
    logic signed [31:0]            out_payload;
    logic [spq_pkg::OCC_W-1:0]     occupancy;

    int tx_idle_pct = 23;
    int rx_idle_pct = 59;

    spq_check_pkg::queue_scoreboard sb = new();

    // 10-unit clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    sorted_priority_queue_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .opcode       (opcode),
        .priority_req (priority_req),
        .payload      (payload),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .out_priority (out_priority),
        .out_payload  (out_payload),
        .occupancy    (occupancy)
    );

    // Drive one request beat; entered and left on a rising edge
    task automatic send_request(input logic op, input logic [15:0] pr, input logic [31:0] pl);
        logic taken;
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        opcode       <= op;
        priority_req <= pr;
        payload      <= pl;
        taken = 1'b0;
        // ready is sampled mid-cycle, the beat moves on the following edge
        while (!taken)
        begin
            @(negedge clk);
            taken = in_ready;
            @(posedge clk);
        end
        sb.note_request(op, pr, pl);
    endtask

    // Random request; ins_pct steers the queue toward full or empty
    task automatic send_random(input int ins_pct);
        logic        op;
        logic [15:0] pr;
        int          sel;
        op  = ($urandom_range(99) < ins_pct) ? spq_pkg::OP_INSERT : spq_pkg::OP_REMOVE;
        sel = int'($urandom_range(9));
        if (sel < 4)
            pr = 16'($urandom_range(7));          // narrow range: lots of ties
        else if (sel == 4)
            pr = '0;
        else if (sel == 5)
            pr = 16'hFFFF;
        else
            pr = 16'($urandom_range(16'hFFFF));
        send_request(op, pr, $urandom);
    endtask

    // Result side: random stalls, sample mid-cycle, check on the accepting edge
    initial
    begin
        logic                       take;
        logic [1:0]                 st;
        logic [15:0]                pr;
        logic [31:0]                pl;
        logic [spq_pkg::OCC_W-1:0]  occ;
        forever
        begin
            @(negedge clk);
            take = rst_n && out_valid && out_ready;
            st   = status;
            pr   = out_priority;
            pl   = out_payload;
            occ  = occupancy;
            @(posedge clk);
            if (take)
                sb.check_response(st, pr, pl, occ);
            out_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Stimulus
    initial
    begin
        int ins_pct;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty remove, extremes, ties at head, middle and tail
        send_request(spq_pkg::OP_REMOVE, 16'h1234, 32'h1234_5678);
        send_request(spq_pkg::OP_INSERT, 16'hFFFF, 32'h7FFF_FFFF);
        send_request(spq_pkg::OP_INSERT, 16'h0000, 32'h8000_0000);
        send_request(spq_pkg::OP_INSERT, 16'h8000, 32'hFFFF_FFFF);
        send_request(spq_pkg::OP_INSERT, 16'h8000, 32'h0000_0001);
        send_request(spq_pkg::OP_INSERT, 16'h8000, 32'h0000_0002);
        send_request(spq_pkg::OP_INSERT, 16'h0000, 32'h0000_0000);
        send_request(spq_pkg::OP_INSERT, 16'hFFFF, 32'h0000_0000);
        send_request(spq_pkg::OP_INSERT, 16'h5555, 32'h5555_5555);
        send_request(spq_pkg::OP_INSERT, 16'hAAAA, 32'hAAAA_AAAA);
        repeat (11) send_request(spq_pkg::OP_REMOVE, 16'hFFFF, 32'hFFFF_FFFF);

        // random: segments alternate fill, hover, drain so full and empty recur
        for (int k = 0; k < 1900; k++)
        begin
            if (k == 633)
            begin
                tx_idle_pct = 59;
                rx_idle_pct = 23;
            end
            else if (k == 1266)
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            case ((k / 120) % 4)
                0:       ins_pct = 85;
                2:       ins_pct = 15;
                default: ins_pct = 50;
            endcase
            send_random(ins_pct);
        end
        in_valid <= 1'b0;

        // drain, then wait for any stray beat
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (5) @(posedge clk);
        if (sb.errors == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2_000_000;
        $display("tb: done, errors");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/sorted_priority_queue_top.sv
verif/spq_check_pkg.sv
verif/tb.sv
